// ===== hw/rtl/pchcrc_pkg.sv =====
// Shared types, constants and CRC tables for the packet header CRC generator.
// Depends on nothing; every other file of the block imports it.
package pchcrc_pkg;

  localparam int LEN_W           = 11;
  localparam int SEQ_W           = 32;
  localparam int WORD_W          = 32;
  localparam int CRC_W           = 32;
  localparam int MAX_PAYLOAD_DEF = 1456;
  localparam int HDR_BYTES       = 16;

  localparam logic [CRC_W-1:0] CRC_POLY = 32'hEDB88320;
  localparam logic [CRC_W-1:0] CRC_INIT = 32'hFFFFFFFF;

  localparam logic [1:0] TYPE_DATA = 2'd1;
  localparam logic [1:0] TYPE_FIN  = 2'd2;

  localparam logic FUNC_START = 1'b0;
  localparam logic FUNC_BYTE  = 1'b1;

  localparam logic [1:0] WORD_TYPE = 2'd0;
  localparam logic [1:0] WORD_SEQ  = 2'd1;
  localparam logic [1:0] WORD_LEN  = 2'd2;
  localparam logic [1:0] WORD_CRC  = 2'd3;

  typedef struct packed {
    logic [1:0]       pkt_type;
    logic [SEQ_W-1:0] seq;
    logic [LEN_W-1:0] total_len;
    logic [CRC_W-1:0] crc;
  } hdr_t;

  typedef logic [255:0][CRC_W-1:0]   crc_byte_tab_t;
  typedef logic [SEQ_W-1:0][CRC_W-1:0] crc_seq_tab_t;
  typedef logic [LEN_W-1:0][CRC_W-1:0] crc_len_tab_t;

  // Bit-serial reference forms, evaluated at elaboration only.
  function automatic logic [CRC_W-1:0] crc_byte_slow(logic [CRC_W-1:0] crc, logic [7:0] b);
    logic [CRC_W-1:0] c;
    c = crc ^ {24'h0, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

  function automatic logic [CRC_W-1:0] crc_word_le(logic [CRC_W-1:0] crc, logic [31:0] w);
    logic [CRC_W-1:0] c;
    c = crc;
    for (int k = 0; k < 4; k++) begin
      c = crc_byte_slow(c, w[8*k +: 8]);
    end
    return c;
  endfunction

  function automatic crc_byte_tab_t make_byte_tab();
    crc_byte_tab_t t;
    for (int i = 0; i < 256; i++) begin
      t[i] = crc_byte_slow('0, 8'(i));
    end
    return t;
  endfunction

  function automatic crc_seq_tab_t make_seq_tab();
    crc_seq_tab_t t;
    for (int i = 0; i < SEQ_W; i++) begin
      t[i] = crc_word_le(crc_word_le('0, 32'(1) << i), 32'h0);
    end
    return t;
  endfunction

  function automatic crc_len_tab_t make_len_tab();
    crc_len_tab_t t;
    for (int i = 0; i < LEN_W; i++) begin
      t[i] = crc_word_le('0, 32'(1) << i);
    end
    return t;
  endfunction

  localparam crc_byte_tab_t CRC_BYTE_TAB = make_byte_tab();
  localparam crc_seq_tab_t  CRC_SEQ_TAB  = make_seq_tab();
  localparam crc_len_tab_t  CRC_LEN_TAB  = make_len_tab();

  localparam logic [CRC_W-1:0] CRC_BASE_DATA =
    crc_word_le(crc_word_le(crc_word_le(CRC_INIT, 32'(TYPE_DATA)), 32'h0), 32'h0);
  localparam logic [CRC_W-1:0] CRC_BASE_FIN =
    crc_word_le(crc_word_le(crc_word_le(CRC_INIT, 32'(TYPE_FIN)), 32'h0), 32'h0);

endpackage

// ===== hw/rtl/pchcrc_crc.sv =====
// CRC-32 datapath: header-field CRC for a start beat and one-byte update for a payload beat.
// Depends on pchcrc_pkg for the constant tables.
module pchcrc_crc (
  input  logic                       is_fin,
  input  logic [pchcrc_pkg::SEQ_W-1:0] seq,
  input  logic [pchcrc_pkg::LEN_W-1:0] total_len,
  input  logic [pchcrc_pkg::CRC_W-1:0] crc_in,
  input  logic [7:0]                 data_byte,
  output logic [pchcrc_pkg::CRC_W-1:0] start_crc,
  output logic [pchcrc_pkg::CRC_W-1:0] byte_crc
);
  import pchcrc_pkg::*;

  logic [7:0] tab_idx;

  // The CRC is affine in its data, so the header contribution is a sum of table columns.
  always_comb begin
    start_crc = is_fin ? CRC_BASE_FIN : CRC_BASE_DATA;
    for (int i = 0; i < SEQ_W; i++) begin
      if (seq[i]) begin
        start_crc = start_crc ^ CRC_SEQ_TAB[i];
      end
    end
    for (int j = 0; j < LEN_W; j++) begin
      if (total_len[j]) begin
        start_crc = start_crc ^ CRC_LEN_TAB[j];
      end
    end
  end

  assign tab_idx  = crc_in[7:0] ^ data_byte;
  assign byte_crc = (crc_in >> 8) ^ CRC_BYTE_TAB[tab_idx];

endmodule

// ===== hw/rtl/pchcrc_emit.sv =====
// Header output stage: one header being sent word by word and one waiting behind it.
// Depends on pchcrc_pkg for the header type and word index codes.
module pchcrc_emit (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        push,
  input  pchcrc_pkg::hdr_t            hdr_in,
  output logic                        full,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [pchcrc_pkg::WORD_W-1:0] out_header_word,
  output logic [1:0]                  out_word_index,
  output logic                        out_last_word
);
  import pchcrc_pkg::*;

  hdr_t       act_r, act_nxt, pend_r, pend_nxt;
  logic       act_valid_r, act_valid_nxt, pend_valid_r, pend_valid_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       out_fire, act_free;

  assign out_fire = act_valid_r && !out_stall;
  assign act_free = !act_valid_r || (out_fire && cnt_r == WORD_CRC);

  always_comb begin
    act_nxt        = act_r;
    pend_nxt       = pend_r;
    act_valid_nxt  = act_valid_r;
    pend_valid_nxt = pend_valid_r;
    cnt_nxt        = cnt_r;
    if (out_fire && cnt_r != WORD_CRC) begin
      cnt_nxt = cnt_r + 2'd1;
    end
    if (act_free) begin
      cnt_nxt = WORD_TYPE;
      if (pend_valid_r) begin
        act_nxt        = pend_r;
        act_valid_nxt  = 1'b1;
        pend_nxt       = hdr_in;
        pend_valid_nxt = push;
      end else begin
        act_nxt       = hdr_in;
        act_valid_nxt = push;
      end
    end else if (push) begin
      pend_nxt       = hdr_in;
      pend_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_valid_r  <= 1'b0;
      pend_valid_r <= 1'b0;
      cnt_r        <= WORD_TYPE;
    end else begin
      act_valid_r  <= act_valid_nxt;
      pend_valid_r <= pend_valid_nxt;
      cnt_r        <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    act_r  <= act_nxt;
    pend_r <= pend_nxt;
  end

  always_comb begin
    case (cnt_r)
      WORD_TYPE: out_header_word = WORD_W'(act_r.pkt_type);
      WORD_SEQ:  out_header_word = WORD_W'(act_r.seq);
      WORD_LEN:  out_header_word = WORD_W'(act_r.total_len);
      WORD_CRC:  out_header_word = ~act_r.crc;
      default:   out_header_word = '0;
    endcase
  end

  assign full           = pend_valid_r;
  assign out_valid      = act_valid_r;
  assign out_word_index = cnt_r;
  assign out_last_word  = (cnt_r == WORD_CRC);

endmodule

// ===== hw/rtl/packet_header_crc_generator_top.sv =====
// Top level of the packet header CRC generator: packet control and sequence state.
// Depends on pchcrc_pkg, pchcrc_crc and pchcrc_emit.
//
// Each start beat opens a packet and each payload beat adds one byte to its CRC; one beat is
// taken every clock cycle while in_stall is low, so a data packet of N bytes uses N+1 input
// beats and a FIN packet one. The header CRC over type, sequence and length is formed from
// constant tables, and a payload byte through a 256-entry table. Every header leaves as four
// output beats, one per cycle while out_stall is low, so a run of FIN packets is paced by the
// output stage; in_stall rises only while a finished header waits behind the one being sent.
module packet_header_crc_generator_top #(
  parameter int MAX_PAYLOAD = pchcrc_pkg::MAX_PAYLOAD_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          in_func,
  input  logic [pchcrc_pkg::LEN_W-1:0]  in_payload_length,
  input  logic [7:0]                    in_data_byte,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [pchcrc_pkg::WORD_W-1:0] out_header_word,
  output logic [1:0]                    out_word_index,
  output logic                          out_last_word
);
  import pchcrc_pkg::*;

  localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_PAYLOAD);

  logic [SEQ_W-1:0] seq_r, seq_nxt;
  logic [CRC_W-1:0] crc_r, crc_nxt;
  logic [LEN_W-1:0] remain_r, remain_nxt, total_r, total_nxt;
  logic             open_r, open_nxt;

  logic             in_fire, is_fin, push, full;
  logic [LEN_W-1:0] len_sat, total_len, remain_dec;
  logic [CRC_W-1:0] start_crc, byte_crc;
  hdr_t             hdr;

  assign in_fire    = in_valid && !in_stall;
  assign in_stall   = full;
  assign len_sat    = (in_payload_length > MAX_LEN) ? MAX_LEN : in_payload_length;
  assign is_fin     = (len_sat == '0);
  assign total_len  = len_sat + LEN_W'(HDR_BYTES);
  assign remain_dec = remain_r - LEN_W'(1);

  pchcrc_crc u_crc (
    .is_fin    (is_fin),
    .seq       (seq_r),
    .total_len (total_len),
    .crc_in    (crc_r),
    .data_byte (in_data_byte),
    .start_crc (start_crc),
    .byte_crc  (byte_crc)
  );

  always_comb begin
    seq_nxt       = seq_r;
    crc_nxt       = crc_r;
    remain_nxt    = remain_r;
    total_nxt     = total_r;
    open_nxt      = open_r;
    push          = 1'b0;
    hdr.pkt_type  = TYPE_DATA;
    hdr.seq       = seq_r;
    hdr.total_len = total_r;
    hdr.crc       = byte_crc;
    if (in_fire) begin
      case (in_func)
        FUNC_START: begin
          total_nxt = total_len;
          if (is_fin) begin
            push          = 1'b1;
            hdr.pkt_type  = TYPE_FIN;
            hdr.total_len = total_len;
            hdr.crc       = start_crc;
            seq_nxt       = seq_r + SEQ_W'(1);
            crc_nxt       = CRC_INIT;
            remain_nxt    = '0;
            open_nxt      = 1'b0;
          end else begin
            crc_nxt    = start_crc;
            remain_nxt = len_sat;
            open_nxt   = 1'b1;
          end
        end
        FUNC_BYTE: begin
          if (open_r) begin
            if (remain_dec == '0) begin
              push       = 1'b1;
              seq_nxt    = seq_r + SEQ_W'(1);
              crc_nxt    = CRC_INIT;
              remain_nxt = '0;
              open_nxt   = 1'b0;
            end else begin
              crc_nxt    = byte_crc;
              remain_nxt = remain_dec;
            end
          end
        end
        default: begin
          open_nxt = open_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seq_r    <= '0;
      crc_r    <= CRC_INIT;
      remain_r <= '0;
      total_r  <= '0;
      open_r   <= 1'b0;
    end else begin
      seq_r    <= seq_nxt;
      crc_r    <= crc_nxt;
      remain_r <= remain_nxt;
      total_r  <= total_nxt;
      open_r   <= open_nxt;
    end
  end

  pchcrc_emit u_emit (
    .clk             (clk),
    .rst_n           (rst_n),
    .push            (push),
    .hdr_in          (hdr),
    .full            (full),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_header_word (out_header_word),
    .out_word_index  (out_word_index),
    .out_last_word   (out_last_word)
  );

endmodule

// ===== hw/rtl/pchcrc_chk.sv =====
// Port-level checks on the packet header CRC generator, bound to its top level.
// Depends on pchcrc_pkg and packet_header_crc_generator_top.
module pchcrc_chk (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_stall,
  input logic                          in_func,
  input logic [pchcrc_pkg::LEN_W-1:0]  in_payload_length,
  input logic                          out_valid,
  input logic                          out_stall,
  input logic [pchcrc_pkg::WORD_W-1:0] out_header_word,
  input logic [1:0]                    out_word_index,
  input logic                          out_last_word
);
  import pchcrc_pkg::*;

  // A stalled output beat holds its whole payload.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_header_word)
      && $stable(out_word_index) && $stable(out_last_word))
    else $error("stalled output beat changed");

  // The last-word flag marks the checksum word and no other.
  a_last_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_last_word == (out_word_index == WORD_CRC)))
    else $error("last-word flag does not match the word index");

  // Header words follow one another without a gap.
  a_word_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && out_word_index != WORD_CRC |=>
      out_valid && out_word_index == 2'($past(out_word_index) + 2'd1))
    else $error("header word sequence broken");

  // A FIN request on an idle output shows its type word in the next cycle.
  a_fin_start: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_func == FUNC_START && in_payload_length == '0 && !out_valid
      |=> out_valid && out_word_index == WORD_TYPE && out_header_word == WORD_W'(TYPE_FIN))
    else $error("FIN header did not start");

endmodule

bind packet_header_crc_generator_top pchcrc_chk u_pchcrc_chk (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_valid          (in_valid),
  .in_stall          (in_stall),
  .in_func           (in_func),
  .in_payload_length (in_payload_length),
  .out_valid         (out_valid),
  .out_stall         (out_stall),
  .out_header_word   (out_header_word),
  .out_word_index    (out_word_index),
  .out_last_word     (out_last_word)
);

// ===== tb/packet_header_crc_generator_top_test.sv =====
// Self-checking testbench for packet_header_crc_generator_top: a directed table, then random
// packets under several idling patterns, every header beat checked against a local predictor.
// Depends on pchcrc_pkg and the RTL of the block only.
module packet_header_crc_generator_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  import pchcrc_pkg::*;

  typedef struct {
    logic [WORD_W-1:0] word;
    logic [1:0]        index;
    logic              last;
  } header_beat_t;

  typedef struct {
    logic             func;
    logic [LEN_W-1:0] len;
    logic [7:0]       data;
    bit               typed;
    int               t_type;
    int               t_seq;
    int               t_len;
  } stim_row_t;

  typedef enum int {
    PH_FREE,
    PH_SEND_IDLE,
    PH_RECV_STALL,
    PH_BOTH,
    PH_PRESSURE
  } idle_phase_e;

  localparam int N_ROWS = 21;
  localparam int HOLD_CYCLES = 300;

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_stall;
  logic                 in_func;
  logic [LEN_W-1:0]     in_payload_length;
  logic [7:0]           in_data_byte;
  logic                 out_valid;
  logic                 out_stall;
  logic [WORD_W-1:0]    out_header_word;
  logic [1:0]           out_word_index;
  logic                 out_last_word;

  idle_phase_e          phase = PH_FREE;
  header_beat_t         expected_beats[$];
  header_beat_t         new_beats[4];
  stim_row_t            directed_rows[N_ROWS];

  logic [SEQ_W-1:0]     hdr_seq;
  logic [CRC_W-1:0]     hdr_crc;
  logic [LEN_W-1:0]     hdr_left;
  logic [LEN_W-1:0]     hdr_total;
  logic                 hdr_open;
  logic [1:0]           hdr_type;

  int failures = 0;
  int n_counted = 0;
  int n_stray = 0;
  int n_dropped = 0;
  int n_headers = 0;
  int n_checked = 0;

  packet_header_crc_generator_top i_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_func           (in_func),
    .in_payload_length (in_payload_length),
    .in_data_byte      (in_data_byte),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_header_word   (out_header_word),
    .out_word_index    (out_word_index),
    .out_last_word     (out_last_word)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [CRC_W-1:0] crc32_feed_byte(logic [CRC_W-1:0] c, logic [7:0] b);
    logic [CRC_W-1:0] r;
    r = c ^ CRC_W'(b);
    repeat (8) begin
      if (r[0]) begin
        r = (r >> 1) ^ CRC_POLY;
      end else begin
        r = r >> 1;
      end
    end
    return r;
  endfunction

  function automatic logic [CRC_W-1:0] crc32_feed_word_le(logic [CRC_W-1:0] c, logic [31:0] w);
    logic [CRC_W-1:0] r;
    r = c;
    for (int k = 0; k < 4; k++) begin
      r = crc32_feed_byte(r, w[8*k +: 8]);
    end
    return r;
  endfunction

  function automatic int close_header();
    new_beats[0] = '{WORD_W'(hdr_type), WORD_TYPE, 1'b0};
    new_beats[1] = '{hdr_seq, WORD_SEQ, 1'b0};
    new_beats[2] = '{WORD_W'(hdr_total), WORD_LEN, 1'b0};
    new_beats[3] = '{~hdr_crc, WORD_CRC, 1'b1};
    hdr_seq  = hdr_seq + 1;
    hdr_crc  = CRC_INIT;
    hdr_open = 1'b0;
    hdr_left = '0;
    return 4;
  endfunction

  // Returns the number of header beats that the beat causes, left in new_beats.
  function automatic int step_header_model(logic func, logic [LEN_W-1:0] len_in,
                                           logic [7:0] data);
    logic [LEN_W-1:0] len;
    int produced;
    produced = 0;
    if (func == FUNC_START) begin
      len = (len_in > LEN_W'(MAX_PAYLOAD_DEF)) ? LEN_W'(MAX_PAYLOAD_DEF) : len_in;
      hdr_open  = 1'b0;
      hdr_type  = (len == '0) ? TYPE_FIN : TYPE_DATA;
      hdr_total = LEN_W'(len + LEN_W'(HDR_BYTES));
      hdr_crc   = crc32_feed_word_le(CRC_INIT, 32'(hdr_type));
      hdr_crc   = crc32_feed_word_le(hdr_crc, hdr_seq);
      hdr_crc   = crc32_feed_word_le(hdr_crc, 32'(hdr_total));
      if (len == '0) begin
        produced = close_header();
      end else begin
        hdr_left = len;
        hdr_open = 1'b1;
      end
    end else if (hdr_open) begin
      hdr_crc  = crc32_feed_byte(hdr_crc, data);
      hdr_left = hdr_left - 1'b1;
      if (hdr_left == '0) begin
        produced = close_header();
      end
    end
    return produced;
  endfunction

  function automatic int sender_idle_pct(idle_phase_e p);
    case (p)
      PH_SEND_IDLE: return 71;
      PH_BOTH:      return 29;
      default:      return 0;
    endcase
  endfunction

  function automatic int receiver_stall_pct(idle_phase_e p);
    case (p)
      PH_RECV_STALL: return 71;
      PH_BOTH:       return 29;
      default:       return 0;
    endcase
  endfunction

  task automatic offer_beat(logic func, logic [LEN_W-1:0] len, logic [7:0] data);
    while ($urandom_range(0, 99) < sender_idle_pct(phase)) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid          <= 1'b1;
    in_func           <= func;
    in_payload_length <= len;
    in_data_byte      <= data;
    @(posedge clk);
    while (in_stall) begin
      @(posedge clk);
    end
  endtask

  task automatic offer_and_predict(logic func, logic [LEN_W-1:0] len, logic [7:0] data,
                                   output int produced);
    offer_beat(func, len, data);
    if (func == FUNC_BYTE && !hdr_open) begin
      n_stray++;
    end else begin
      n_counted++;
      if (func == FUNC_START && hdr_open) begin
        n_dropped++;
      end
    end
    produced = step_header_model(func, len, data);
    for (int k = 0; k < produced; k++) begin
      expected_beats.push_back(new_beats[k]);
    end
    if (produced != 0) begin
      n_headers++;
    end
  endtask

  task automatic send_random_packet();
    int pick;
    int len;
    int sent;
    int produced;
    pick = $urandom_range(0, 99);
    if (pick < 6) begin
      repeat ($urandom_range(1, 3)) begin
        offer_and_predict(FUNC_BYTE, LEN_W'($urandom_range(0, 2047)),
                          8'($urandom_range(0, 255)), produced);
      end
    end else begin
      if (pick < 18) begin
        len = 0;
      end else if (pick < 21) begin
        len = $urandom_range(MAX_PAYLOAD_DEF + 1, 2047);
      end else if (pick < 36) begin
        len = $urandom_range(9, 64);
      end else begin
        len = $urandom_range(1, 8);
      end
      offer_and_predict(FUNC_START, LEN_W'(len), 8'($urandom_range(0, 255)), produced);
      if (len > MAX_PAYLOAD_DEF) begin
        sent = $urandom_range(0, 20);
      end else if (len > 0 && $urandom_range(0, 99) < 8) begin
        sent = $urandom_range(0, len - 1);
      end else begin
        sent = len;
      end
      repeat (sent) begin
        offer_and_predict(FUNC_BYTE, LEN_W'($urandom_range(0, 2047)),
                          8'($urandom_range(0, 255)), produced);
      end
    end
  endtask

  task automatic run_random_phase(idle_phase_e p, int beats);
    int target;
    phase  = p;
    target = n_counted + beats;
    while (n_counted < target) begin
      send_random_packet();
    end
  endtask

  // Receiver: checks each accepted beat, then decides the stall for the next cycle.
  initial begin
    header_beat_t want;
    int hold_left;
    bit held;
    hold_left = 0;
    held      = 1'b0;
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid === 1'b1 && !out_stall) begin
        if (expected_beats.size() == 0) begin
          $error("unexpected header beat: word %h, index %0d", out_header_word, out_word_index);
          failures++;
        end else begin
          want = expected_beats.pop_front();
          n_checked++;
          if (out_header_word !== want.word) begin
            $error("header_word: expected %h, got %h", want.word, out_header_word);
            failures++;
          end
          if (out_word_index !== want.index) begin
            $error("word_index: expected %0d, got %0d", want.index, out_word_index);
            failures++;
          end
          if (out_last_word !== want.last) begin
            $error("last_word: expected %0d, got %0d", want.last, out_last_word);
            failures++;
          end
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (phase == PH_PRESSURE && !held) begin
        held      = 1'b1;
        hold_left = HOLD_CYCLES - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(0, 99) < receiver_stall_pct(phase));
      end
    end
  end

  initial begin
    #5_000_000;
    $display("FAILED: results differ");
    $finish;
  end

  initial begin
    int produced;
    int idx;
    int wait_cycles;
    header_beat_t tmp;
    rst_n             = 1'b0;
    in_valid          = 1'b0;
    in_func           = FUNC_START;
    in_payload_length = '0;
    in_data_byte      = '0;
    hdr_seq   = '0;
    hdr_crc   = CRC_INIT;
    hdr_left  = '0;
    hdr_total = '0;
    hdr_open  = 1'b0;
    hdr_type  = '0;
    directed_rows = '{
      '{FUNC_START, 11'd0,    8'h00, 1'b1, TYPE_FIN,  0, 16},
      '{FUNC_BYTE,  11'd0,    8'h00, 1'b0, 0, 0, 0},
      '{FUNC_BYTE,  11'd2047, 8'hFF, 1'b0, 0, 0, 0},
      '{FUNC_START, 11'd1,    8'h00, 1'b0, 0, 0, 0},
      '{FUNC_BYTE,  11'd0,    8'hFF, 1'b1, TYPE_DATA, 1, 17},
      '{FUNC_START, 11'd2047, 8'hFF, 1'b0, 0, 0, 0},
      '{FUNC_START, 11'd3,    8'h00, 1'b0, 0, 0, 0},
      '{FUNC_BYTE,  11'd0,    8'h00, 1'b0, 0, 0, 0},
      '{FUNC_BYTE,  11'd5,    8'hA5, 1'b0, 0, 0, 0},
      '{FUNC_BYTE,  11'd0,    8'h5A, 1'b1, TYPE_DATA, 2, 19},
      '{FUNC_START, 11'd1457, 8'h00, 1'b0, 0, 0, 0},
      '{FUNC_START, 11'd0,    8'h00, 1'b1, TYPE_FIN,  3, 16},
      '{FUNC_START, 11'd1456, 8'h00, 1'b0, 0, 0, 0},
      '{FUNC_START, 11'd2,    8'h00, 1'b0, 0, 0, 0},
      '{FUNC_BYTE,  11'd0,    8'h80, 1'b0, 0, 0, 0},
      '{FUNC_BYTE,  11'd0,    8'h01, 1'b0, 0, 0, 0},
      '{FUNC_START, 11'd0,    8'h00, 1'b1, TYPE_FIN,  5, 16},
      '{FUNC_BYTE,  11'd0,    8'h7E, 1'b0, 0, 0, 0},
      '{FUNC_START, 11'd1,    8'h00, 1'b0, 0, 0, 0},
      '{FUNC_BYTE,  11'd0,    8'h3C, 1'b0, 0, 0, 0},
      '{FUNC_START, 11'd0,    8'h00, 1'b0, 0, 0, 0}
    };
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    for (int r = 0; r < N_ROWS; r++) begin
      offer_and_predict(directed_rows[r].func, directed_rows[r].len, directed_rows[r].data,
                        produced);
      if (directed_rows[r].typed) begin
        if (produced != 4) begin
          $error("directed row %0d: a header was due, none predicted", r);
          failures++;
        end else begin
          idx = expected_beats.size() - 4;
          tmp = expected_beats[idx];
          tmp.word = WORD_W'(directed_rows[r].t_type);
          expected_beats[idx] = tmp;
          tmp = expected_beats[idx + 1];
          tmp.word = WORD_W'(directed_rows[r].t_seq);
          expected_beats[idx + 1] = tmp;
          tmp = expected_beats[idx + 2];
          tmp.word = WORD_W'(directed_rows[r].t_len);
          expected_beats[idx + 2] = tmp;
        end
      end
    end

    run_random_phase(PH_FREE, 120);
    run_random_phase(PH_SEND_IDLE, 110);
    run_random_phase(PH_RECV_STALL, 110);
    run_random_phase(PH_BOTH, 90);
    run_random_phase(PH_PRESSURE, 40);
    phase = PH_FREE;
    in_valid <= 1'b0;

    wait_cycles = 0;
    while (expected_beats.size() != 0 && wait_cycles < 20000) begin
      @(posedge clk);
      wait_cycles++;
    end
    repeat (16) @(posedge clk);
    if (expected_beats.size() != 0) begin
      $error("%0d header beats never arrived", expected_beats.size());
      failures++;
    end

    $display("Run covered %0d counted beats, %0d stray bytes, %0d dropped packets, %0d headers.",
             n_counted, n_stray, n_dropped, n_headers);
    $display("Checked %0d header beats under free, sender, receiver and combined idling.",
             n_checked);
    if (failures == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
